// File: design/mswd_pkg.sv
// Shared types and codes for the multi-slot watchdog monitor.
`default_nettype none

package mswd_pkg;

  localparam int TIME_W = 32;
  localparam int KIND_W = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_FIELD_W = 3;
  localparam int MASK_W = 8;

  localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FEED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNREGISTERED = 2'd2;

endpackage

`default_nettype wire

// File: design/multi_slot_watchdog_monitor.sv
// Top level of the multi-slot watchdog monitor.
`default_nettype none

// Keeps SLOTS software watchdog slots, handed out in order from slot 0. An item is
// transferred at a clock edge with start high and busy low; every item gives exactly one
// result, shown for one cycle with done high, and the receiver cannot hold it off.
// Register, feed and unused-kind items need no walk: the result appears in the
// cycle after the transfer and busy stays low, so the next item can follow at once. A
// check item walks the registered slots one per cycle through a single subtract/compare
// unit fed from the slot memories (one registered read per cycle); busy stays high
// through the walk, and done rises in the same cycle that busy falls. A check
// with no registered slot answers in the next cycle. Only slots 0 to 7 show in
// new_timeouts; higher slots are still tracked.
module multi_slot_watchdog_monitor
  import mswd_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [KIND_W-1:0]       kind,
  input  wire logic [TIME_W-1:0]       now_ms,
  input  wire logic [TIME_W-1:0]       limit_ms,
  input  wire logic [SLOT_FIELD_W-1:0] slot_index,
  output logic                         done,
  output logic [STATUS_W-1:0]          status,
  output logic [SLOT_FIELD_W-1:0]      assigned_slot,
  output logic [MASK_W-1:0]            new_timeouts
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > SLOT_FIELD_W) ? CNT_W : SLOT_FIELD_W;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  reg_count;
  logic [SLOTS-1:0]  expired;
  logic [CNT_W-1:0]  ptr;
  logic              chk_vld;
  logic [IDX_W-1:0]  chk_idx;
  logic [TIME_W-1:0] now_q;

  logic [TIME_W-1:0] slot_timeout [SLOTS];
  logic [TIME_W-1:0] last_feed_time [SLOTS];
  logic [TIME_W-1:0] tmo_rd;
  logic [TIME_W-1:0] feed_rd;

  logic              accept;
  logic              table_full;
  logic              feed_ok;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              tmo_we;
  logic              feed_we;
  logic [IDX_W-1:0]  wr_addr;
  logic              rd_en;
  logic              unit_expired;
  logic              chk_hit;
  logic [MASK_W-1:0] hit_mask;

  assign busy = (state == S_WALK);
  assign accept = start && !busy;

  assign table_full = (reg_count == CNT_W'(SLOTS));
  assign idx_ext = CMP_W'(slot_index);
  assign cnt_ext = CMP_W'(reg_count);
  assign feed_ok = idx_ext < cnt_ext;

  assign tmo_we = accept && (kind == KIND_REGISTER) && !table_full;
  assign feed_we = tmo_we || (accept && (kind == KIND_FEED) && feed_ok);
  assign wr_addr = (kind == KIND_REGISTER) ? reg_count[IDX_W-1:0] : idx_ext[IDX_W-1:0];

  assign rd_en = (state == S_WALK) && (ptr < reg_count);

  // Slot memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (tmo_we) begin
      slot_timeout[wr_addr] <= limit_ms;
    end
    if (feed_we) begin
      last_feed_time[wr_addr] <= now_ms;
    end
    if (rd_en) begin
      tmo_rd <= slot_timeout[ptr[IDX_W-1:0]];
      feed_rd <= last_feed_time[ptr[IDX_W-1:0]];
    end
  end

  mswd_expiry_unit u_expiry (
    .now_ms    (now_q),
    .last_feed (feed_rd),
    .limit     (tmo_rd),
    .expired   (unit_expired)
  );

  assign chk_hit = chk_vld && unit_expired && !expired[chk_idx];

  always_comb begin
    for (int j = 0; j < MASK_W; j++) begin
      hit_mask[j] = chk_hit && (32'(chk_idx) == j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      reg_count <= '0;
      expired <= '0;
      chk_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            status <= ST_OK;
            assigned_slot <= '0;
            new_timeouts <= '0;
            case (kind)
              KIND_REGISTER: begin
                done <= 1'b1;
                if (table_full) begin
                  status <= ST_FULL;
                end else begin
                  assigned_slot <= SLOT_FIELD_W'(reg_count);
                  expired[reg_count[IDX_W-1:0]] <= 1'b0;
                  reg_count <= CNT_W'(reg_count + 1'b1);
                end
              end
              KIND_FEED: begin
                done <= 1'b1;
                if (feed_ok) begin
                  expired[idx_ext[IDX_W-1:0]] <= 1'b0;
                end else begin
                  status <= ST_UNREGISTERED;
                end
              end
              KIND_CHECK: begin
                now_q <= now_ms;
                ptr <= '0;
                chk_vld <= 1'b0;
                if (reg_count == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_WALK;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_WALK: begin
          // read of slot ptr overlaps the compare of the slot read last cycle
          chk_vld <= rd_en;
          chk_idx <= ptr[IDX_W-1:0];
          if (rd_en) begin
            ptr <= CNT_W'(ptr + 1'b1);
          end
          if (chk_hit) begin
            expired[chk_idx] <= 1'b1;
            new_timeouts <= new_timeouts | hit_mask;
          end
          if (!rd_en && !chk_vld) begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    reg_count <= CNT_W'(SLOTS))
    else $error("slot count beyond table size");

  a_check_walks: assert property (@(posedge clk) disable iff (rst)
    accept && (kind == KIND_CHECK) && (reg_count != '0) |=> busy && !done)
    else $error("check with registered slots did not walk the table");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (assigned_slot == '0) && (new_timeouts == '0))
    else $error("error result carries slot or mask bits");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> busy && (CNT_W'(chk_idx) < reg_count))
    else $error("compare on a slot outside the registered range");

endmodule

`default_nettype wire

// File: design/mswd_expiry_unit.sv
// Shared elapsed-time unit: wrapping subtract and strict compare against a timeout.
`default_nettype none

module mswd_expiry_unit
  import mswd_pkg::*;
(
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic [TIME_W-1:0] last_feed,
  input  wire logic [TIME_W-1:0] limit,
  output logic                   expired
);

  logic [TIME_W-1:0] elapsed;

  assign elapsed = now_ms - last_feed;
  assign expired = elapsed > limit;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for the multi-slot watchdog monitor: directed table, then random items of every kind.
`timescale 1ns / 100ps

module tb_top;
  import mswd_pkg::*;

  localparam int SLOTS = 8;
  localparam int RANDOM_ITEMS = 1280;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [TIME_W-1:0]       now;
    logic [TIME_W-1:0]       tmo;
    logic [SLOT_FIELD_W-1:0] idx;
  } wd_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [MASK_W-1:0]       mask;
  } wd_reply_t;

  typedef struct packed {
    wd_item_t  item;
    logic      typed;
    wd_reply_t reply;
  } wd_row_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [KIND_W-1:0]       kind = KIND_UNUSED;
  logic [TIME_W-1:0]       now_ms = '0;
  logic [TIME_W-1:0]       limit_ms = '0;
  logic [SLOT_FIELD_W-1:0] slot_index = '0;
  logic                    busy;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_FIELD_W-1:0] assigned_slot;
  logic [MASK_W-1:0]       new_timeouts;

  multi_slot_watchdog_monitor #(.SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .now_ms(now_ms),
    .limit_ms(limit_ms),
    .slot_index(slot_index),
    .done(done),
    .status(status),
    .assigned_slot(assigned_slot),
    .new_timeouts(new_timeouts)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Watchdog table as the block should hold it.
  logic [TIME_W-1:0] slot_tmo [SLOTS];
  logic [TIME_W-1:0] slot_fed_at [SLOTS];
  logic              slot_expired [SLOTS];
  int                slots_used;

  wd_reply_t replies_due[$];
  wd_row_t   directed_rows[$];
  int        errors = 0;
  bit        no_gaps = 1'b0;

  function automatic wd_reply_t watchdog_predict(wd_item_t it);
    wd_reply_t r;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    case (it.kind)
      KIND_REGISTER: begin
        if (slots_used >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          slot_tmo[slots_used] = it.tmo;
          slot_fed_at[slots_used] = it.now;
          slot_expired[slots_used] = 1'b0;
          r.slot = slots_used[SLOT_FIELD_W-1:0];
          slots_used++;
        end
      end
      KIND_FEED: begin
        if (int'(it.idx) >= slots_used || int'(it.idx) >= SLOTS) begin
          r.status = ST_UNREGISTERED;
        end else begin
          slot_fed_at[it.idx] = it.now;
          slot_expired[it.idx] = 1'b0;
        end
      end
      KIND_CHECK: begin
        for (int i = 0; i < slots_used && i < SLOTS; i++) begin
          elapsed = it.now - slot_fed_at[i];
          // strict compare; each expiry reported once until the next feed
          if (elapsed > slot_tmo[i] && !slot_expired[i]) begin
            slot_expired[i] = 1'b1;
            if (i < MASK_W) r.mask[i] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_row(logic [KIND_W-1:0] k, logic [TIME_W-1:0] now, logic [TIME_W-1:0] tmo,
                         logic [SLOT_FIELD_W-1:0] idx, logic typed, logic [STATUS_W-1:0] st,
                         logic [SLOT_FIELD_W-1:0] slot, logic [MASK_W-1:0] mask);
    wd_row_t row;
    row.item = '{kind: k, now: now, tmo: tmo, idx: idx};
    row.typed = typed;
    row.reply = '{status: st, slot: slot, mask: mask};
    directed_rows.push_back(row);
  endtask

  // Drive one item and hold it until the transfer; start stays high on return.
  task automatic send(wd_item_t it, wd_reply_t typed_reply, logic typed);
    wd_reply_t predicted;
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= it.kind;
    now_ms <= it.now;
    limit_ms <= it.tmo;
    slot_index <= it.idx;
    do @(posedge clk); while (busy);
    predicted = watchdog_predict(it);
    replies_due.push_back(typed ? typed_reply : predicted);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  always @(posedge clk) begin
    wd_reply_t want;
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result: status %0d, assigned_slot %0d, new_timeouts %h",
               status, assigned_slot, new_timeouts);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (assigned_slot !== want.slot) begin
          $error("assigned_slot: expected %0d, got %0d", want.slot, assigned_slot);
          errors++;
        end
        if (new_timeouts !== want.mask) begin
          $error("new_timeouts: expected %h, got %h", want.mask, new_timeouts);
          errors++;
        end
      end
    end
  end

  initial begin
    wd_item_t it;
    logic [TIME_W-1:0] clock_ms;
    int dice;

    for (int i = 0; i < SLOTS; i++) slot_expired[i] = 1'b0;
    slots_used = 0;

    // empty table
    add_row(KIND_CHECK,    32'd0,        32'd0,        3'd0, 1'b1, ST_OK,         3'd0, 8'h00);
    add_row(KIND_FEED,     32'd5,        32'd0,        3'd0, 1'b1, ST_UNREGISTERED, 3'd0, 8'h00);
    add_row(KIND_FEED,     32'd5,        32'hFFFFFFFF, 3'd7, 1'b1, ST_UNREGISTERED, 3'd0, 8'h00);
    add_row(KIND_UNUSED,   32'd9,        32'd9,        3'd5, 1'b1, ST_OK,         3'd0, 8'h00);
    // timeout extremes
    add_row(KIND_REGISTER, 32'd0,        32'd0,        3'd7, 1'b1, ST_OK,         3'd0, 8'h00);
    add_row(KIND_REGISTER, 32'hFFFFFFFF, 32'hFFFFFFFF, 3'd0, 1'b1, ST_OK,         3'd1, 8'h00);
    add_row(KIND_REGISTER, 32'd100,      32'd5,        3'd3, 1'b1, ST_OK,         3'd2, 8'h00);
    // elapsed wraps around zero
    add_row(KIND_CHECK,    32'd0,        32'hFFFFFFFF, 3'd7, 1'b0, ST_OK,         3'd0, 8'h00);
    add_row(KIND_CHECK,    32'd1,        32'd0,        3'd0, 1'b0, ST_OK,         3'd0, 8'h00);
    add_row(KIND_CHECK,    32'd1,        32'd0,        3'd0, 1'b0, ST_OK,         3'd0, 8'h00);
    add_row(KIND_FEED,     32'd105,      32'h12345678, 3'd2, 1'b1, ST_OK,         3'd0, 8'h00);
    // elapsed equal to timeout does not expire, one more does
    add_row(KIND_CHECK,    32'd110,      32'd0,        3'd1, 1'b0, ST_OK,         3'd0, 8'h00);
    add_row(KIND_CHECK,    32'd111,      32'd0,        3'd1, 1'b0, ST_OK,         3'd0, 8'h00);
    add_row(KIND_FEED,     32'd112,      32'd0,        3'd3, 1'b1, ST_UNREGISTERED, 3'd0, 8'h00);
    add_row(KIND_REGISTER, 32'd120,      32'd10,       3'd1, 1'b1, ST_OK,         3'd3, 8'h00);
    add_row(KIND_REGISTER, 32'd121,      32'd250,      3'd6, 1'b1, ST_OK,         3'd4, 8'h00);
    add_row(KIND_REGISTER, 32'd122,      32'd1000,     3'd2, 1'b1, ST_OK,         3'd5, 8'h00);
    add_row(KIND_REGISTER, 32'd123,      32'h0000FFFF, 3'd4, 1'b1, ST_OK,         3'd6, 8'h00);
    add_row(KIND_REGISTER, 32'd124,      32'h80000000, 3'd5, 1'b1, ST_OK,         3'd7, 8'h00);
    add_row(KIND_REGISTER, 32'd125,      32'd77,       3'd0, 1'b1, ST_FULL,       3'd0, 8'h00);
    add_row(KIND_FEED,     32'd130,      32'd0,        3'd7, 1'b1, ST_OK,         3'd0, 8'h00);
    add_row(KIND_CHECK,    32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7, 1'b0, ST_OK,         3'd0, 8'h00);
    add_row(KIND_UNUSED,   32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7, 1'b1, ST_OK,         3'd0, 8'h00);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) send(directed_rows[r].item, directed_rows[r].reply,
                                    directed_rows[r].typed);
    drain();

    clock_ms = 32'd200;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n % 300 == 299) drain();
      // mostly small time steps so slots expire at their own pace, now and then a jump
      if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 400);
      dice = $urandom_range(0, 99);
      if (dice < 45) it.kind = KIND_FEED;
      else if (dice < 85) it.kind = KIND_CHECK;
      else if (dice < 95) it.kind = KIND_REGISTER;
      else it.kind = KIND_UNUSED;
      it.now = clock_ms;
      it.tmo = $urandom;
      it.idx = SLOT_FIELD_W'($urandom_range(0, 7));
      send(it, '0, 1'b0);
    end

    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
